>>> rtl/core/msseq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msseq_pkg
// Constants, types and small tables for the MIDI-clocked step sequencer.
// ----------------------------------------------------------------------------
package msseq_pkg;

    // Defaults for the top-level parameters
    localparam int STEPS_DEFAULT      = 16;
    localparam int TICK_WIDTH_DEFAULT = 32;

    // Pattern storage always holds sixteen steps
    localparam int PATTERN_DEPTH = 16;
    localparam int NOTE_W        = 7;
    localparam int STEP_W        = 4;
    localparam int LIMIT_W       = 5;
    localparam int CHAN_W        = 4;

    // MIDI status codes
    localparam logic [7:0] STATUS_CLOCK    = 8'hF8;
    localparam logic [7:0] STATUS_START    = 8'hFA;
    localparam logic [3:0] STATUS_CC_HI    = 4'hB;
    localparam logic [3:0] STATUS_NOTE_ON  = 4'h9;
    localparam logic [3:0] STATUS_NOTE_OFF = 4'h8;

    // Controller numbers
    localparam logic [6:0] CC_STEP_FIRST = 7'd1;
    localparam logic [6:0] CC_STEP_LAST  = 7'd16;
    localparam logic [6:0] CC_VEL_LOW    = 7'd25;
    localparam logic [6:0] CC_VEL_HIGH   = 7'd26;
    localparam logic [6:0] CC_DIVISION   = 7'd29;
    localparam logic [6:0] CC_GATE       = 7'd30;
    localparam logic [6:0] CC_LIMIT      = 7'd31;
    localparam logic [6:0] CC_CHANNEL    = 7'd32;

    // Note and setting bounds
    localparam logic [6:0] NOTE_REST    = 7'd127;
    localparam logic [6:0] NOTE_ROOT    = 7'd60;
    localparam logic [6:0] DIVISION_MAX = 7'd95;
    localparam logic [6:0] CHANNEL_MAX  = 7'd15;

    // Reset values of the settings
    localparam logic [6:0] DIVISION_RESET = 7'd6;
    localparam logic [6:0] GATE_RESET     = 7'd1;
    localparam logic [6:0] VEL_LOW_RESET  = 7'd99;
    localparam logic [6:0] VEL_HIGH_RESET = 7'd127;

    // Sequencer states, one-hot
    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_DIV_TICK = 6'b000010,
        ST_COPY     = 6'b000100,
        ST_EVAL     = 6'b001000,
        ST_DIV_VEL  = 6'b010000,
        ST_EMIT     = 6'b100000
    } state_t;

    // Largest gate length for a step limit: 96 / limit - 1
    function automatic logic [6:0] gate_max(input logic [LIMIT_W-1:0] limit);
        logic [6:0] g;
        case (limit)
            5'd1:    g = 7'd95;
            5'd2:    g = 7'd47;
            5'd3:    g = 7'd31;
            5'd4:    g = 7'd23;
            5'd5:    g = 7'd18;
            5'd6:    g = 7'd15;
            5'd7:    g = 7'd12;
            5'd8:    g = 7'd11;
            5'd9:    g = 7'd9;
            5'd10:   g = 7'd8;
            5'd11:   g = 7'd7;
            5'd12:   g = 7'd7;
            5'd13:   g = 7'd6;
            5'd14:   g = 7'd5;
            5'd15:   g = 7'd5;
            5'd16:   g = 7'd5;
            default: g = 7'd5;
        endcase
        return g;
    endfunction

    // Power-up pattern: root note on every fourth step, rests elsewhere
    function automatic logic [6:0] pattern_init(input int idx);
        return (idx % 4 == 0) ? NOTE_ROOT : NOTE_REST;
    endfunction

endpackage

>>> rtl/core/midi_clocked_step_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_clocked_step_sequencer
// Sixteen-step note sequencer driven by MIDI clock, start and control change.
// ----------------------------------------------------------------------------
//
//  channel | handshake           | payload
//  --------+---------------------+------------------------------------------
//  in      | in_valid / in_ready | status_byte, data_one, data_two,
//          |                     | random_draw
//  out     | out_valid/out_ready | note_status, note_number, note_velocity
//
//  A start, a control change or any ignored message is handled in the idle
//  state. A clock item runs the shared restoring divider: one quotient bit
//  per cycle for tick / division, then, for a note-on only, seven bits for
//  the velocity draw modulo.
//  Reset (rst_n low, asynchronous) restores tick, step, settings and both
//  patterns at once; no clearing pass.
//  A result waits in the output register; the next clock item that wants
//  to emit holds in its last state until that register has been taken.
//
module midi_clocked_step_sequencer #(
    parameter int STEPS      = msseq_pkg::STEPS_DEFAULT,
    parameter int TICK_WIDTH = msseq_pkg::TICK_WIDTH_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,

    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] status_byte,
    input  logic [6:0] data_one,
    input  logic [6:0] data_two,
    input  logic [6:0] random_draw,

    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] note_status,
    output logic [6:0] note_number,
    output logic [6:0] note_velocity
);
    import msseq_pkg::*;

    localparam int CNT_W    = $clog2(TICK_WIDTH);
    localparam int DRAW_PAD = TICK_WIDTH - NOTE_W;

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    state_t                  state_reg,      state_next;
    logic [TICK_WIDTH-1:0]   tick_reg,       tick_next;
    logic [STEP_W-1:0]       step_index_reg, step_index_next;
    logic                    sounding_reg,   sounding_next;
    logic [NOTE_W-1:0]       playing_reg [PATTERN_DEPTH];
    logic [NOTE_W-1:0]       playing_next[PATTERN_DEPTH];
    logic [NOTE_W-1:0]       pending_reg [PATTERN_DEPTH];
    logic [NOTE_W-1:0]       pending_next[PATTERN_DEPTH];
    logic [6:0]              division_reg,   division_next;
    logic [6:0]              gate_reg,       gate_next;
    logic [LIMIT_W-1:0]      limit_reg,      limit_next;
    logic [CHAN_W-1:0]       channel_reg,    channel_next;
    logic [6:0]              vel_low_reg,    vel_low_next;
    logic [6:0]              vel_high_reg,   vel_high_next;

    // Shared divider: dividend shifts out MSB first, remainder builds up.
    // During the tick pass the quotient bits are folded modulo step limit.
    logic [TICK_WIDTH-1:0]   dividend_reg,   dividend_next;
    logic [NOTE_W-1:0]       rem_reg,        rem_next;
    logic [7:0]              divisor_reg,    divisor_next;
    logic [STEP_W-1:0]       qmod_reg,       qmod_next;
    logic [CNT_W-1:0]        count_reg,      count_next;

    // Per-item scratch
    logic [NOTE_W-1:0]       draw_reg,       draw_next;
    logic [NOTE_W-1:0]       tick_rem_reg,   tick_rem_next;
    logic [NOTE_W-1:0]       note_reg,       note_next;
    logic [NOTE_W-1:0]       vel_reg,        vel_next;
    logic                    is_on_reg,      is_on_next;

    // Output register
    logic                    out_valid_reg,  out_valid_next;
    logic [7:0]              status_o_reg,   status_o_next;
    logic [NOTE_W-1:0]       number_o_reg,   number_o_next;
    logic [NOTE_W-1:0]       velocity_o_reg, velocity_o_next;

    // ------------------------------------------------------------------
    // Divider step
    // ------------------------------------------------------------------
    logic [7:0]         div_shift;
    logic               div_ge;
    logic [7:0]         div_diff;
    logic [NOTE_W-1:0]  rem_step;
    logic [LIMIT_W-1:0] qm_shift;
    logic [LIMIT_W-1:0] qm_diff;
    logic [STEP_W-1:0]  qmod_step;

    assign div_shift = {rem_reg, dividend_reg[TICK_WIDTH-1]};
    assign div_ge    = (div_shift >= divisor_reg);
    assign div_diff  = div_shift - divisor_reg;
    // remainder stays below the divisor, which is at most 128
    assign rem_step  = div_ge ? div_diff[NOTE_W-1:0] : div_shift[NOTE_W-1:0];

    // quotient modulo step limit: (2 * q + bit) mod limit, one subtract
    assign qm_shift  = {qmod_reg, div_ge};
    assign qm_diff   = qm_shift - limit_reg;
    assign qmod_step = (qm_shift >= limit_reg) ? qm_diff[STEP_W-1:0]
                                               : qm_shift[STEP_W-1:0];

    // ------------------------------------------------------------------
    // Control change decode
    // ------------------------------------------------------------------
    logic [STEP_W-1:0] cc_minus_one;
    logic [STEP_W-1:0] cc_step;
    logic [6:0]        cc_gate_max;
    logic [6:0]        span;
    logic              out_free;

    assign cc_minus_one = data_one[STEP_W-1:0] - STEP_W'(1);
    // controllers run in groups of four from the last group to the first
    assign cc_step      = {~cc_minus_one[3:2], cc_minus_one[1:0]};
    assign cc_gate_max  = gate_max(limit_reg);
    assign span         = vel_high_reg - vel_low_reg;
    assign out_free     = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next      = state_reg;
        tick_next       = tick_reg;
        step_index_next = step_index_reg;
        sounding_next   = sounding_reg;
        playing_next    = playing_reg;
        pending_next    = pending_reg;
        division_next   = division_reg;
        gate_next       = gate_reg;
        limit_next      = limit_reg;
        channel_next    = channel_reg;
        vel_low_next    = vel_low_reg;
        vel_high_next   = vel_high_reg;
        dividend_next   = dividend_reg;
        rem_next        = rem_reg;
        divisor_next    = divisor_reg;
        qmod_next       = qmod_reg;
        count_next      = count_reg;
        draw_next       = draw_reg;
        tick_rem_next   = tick_rem_reg;
        note_next       = note_reg;
        vel_next        = vel_reg;
        is_on_next      = is_on_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        status_o_next   = status_o_reg;
        number_o_next   = number_o_reg;
        velocity_o_next = velocity_o_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (status_byte == STATUS_CLOCK)
                    begin
                        tick_next     = tick_reg + TICK_WIDTH'(1);
                        dividend_next = tick_reg + TICK_WIDTH'(1);
                        rem_next      = '0;
                        qmod_next     = '0;
                        divisor_next  = {1'b0, division_reg};
                        count_next    = CNT_W'(TICK_WIDTH - 1);
                        draw_next     = random_draw;
                        state_next    = ST_DIV_TICK;
                    end
                    else if (status_byte == STATUS_START)
                    begin
                        tick_next       = '1;
                        step_index_next = '0;
                    end
                    else if (status_byte[7:4] == STATUS_CC_HI)
                    begin
                        if (data_one >= CC_STEP_FIRST && data_one <= CC_STEP_LAST)
                        begin
                            if ({1'b0, cc_step} < LIMIT_W'(STEPS))
                                pending_next[cc_step] = data_two;
                        end
                        else
                        begin
                            case (data_one)
                                CC_DIVISION:
                                    division_next = (data_two == 7'd0) ? 7'd1 :
                                        (data_two > DIVISION_MAX) ? DIVISION_MAX :
                                        data_two;
                                CC_GATE:
                                    gate_next = (data_two == 7'd0) ? 7'd1 :
                                        (data_two > cc_gate_max) ? cc_gate_max :
                                        data_two;
                                CC_LIMIT:
                                    limit_next = (data_two == 7'd0) ? LIMIT_W'(1) :
                                        (data_two > 7'(STEPS)) ? LIMIT_W'(STEPS) :
                                        data_two[LIMIT_W-1:0];
                                CC_CHANNEL:
                                    channel_next = (data_two > CHANNEL_MAX) ? 4'hF :
                                        data_two[CHAN_W-1:0];
                                CC_VEL_LOW:
                                    vel_low_next = (data_two > vel_high_reg) ?
                                        vel_high_reg : data_two;
                                CC_VEL_HIGH:
                                    vel_high_next = (data_two < vel_low_reg) ?
                                        vel_low_reg : data_two;
                                default: ;
                            endcase
                        end
                    end
                end
            end

            ST_DIV_TICK:
            begin
                dividend_next = {dividend_reg[TICK_WIDTH-2:0], 1'b0};
                rem_next      = rem_step;
                qmod_next     = qmod_step;
                count_next    = count_reg - CNT_W'(1);
                if (count_reg == '0)
                begin
                    step_index_next = qmod_step;
                    tick_rem_next   = rem_step;
                    state_next      = ST_COPY;
                end
            end

            ST_COPY:
            begin
                // step zero takes over the pending pattern
                if (step_index_reg == '0)
                    playing_next = pending_reg;
                state_next = ST_EVAL;
            end

            ST_EVAL:
            begin
                note_next = playing_reg[step_index_reg];
                if (tick_rem_reg == '0 && playing_reg[step_index_reg] != NOTE_REST &&
                    !sounding_reg)
                begin
                    // velocity: draw mod (span + 1), draw sits at the top
                    is_on_next    = 1'b1;
                    dividend_next = {draw_reg, {DRAW_PAD{1'b0}}};
                    rem_next      = '0;
                    divisor_next  = {1'b0, span} + 8'd1;
                    count_next    = CNT_W'(NOTE_W - 1);
                    state_next    = ST_DIV_VEL;
                end
                else if (tick_rem_reg == gate_reg && sounding_reg)
                begin
                    is_on_next = 1'b0;
                    vel_next   = '0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_DIV_VEL:
            begin
                dividend_next = {dividend_reg[TICK_WIDTH-2:0], 1'b0};
                rem_next      = rem_step;
                count_next    = count_reg - CNT_W'(1);
                if (count_reg == '0)
                begin
                    vel_next   = vel_low_reg + rem_step;
                    state_next = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    status_o_next   = {is_on_reg ? STATUS_NOTE_ON : STATUS_NOTE_OFF,
                                       channel_reg};
                    number_o_next   = note_reg;
                    velocity_o_next = vel_reg;
                    sounding_next   = is_on_reg;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            tick_reg       <= '0;
            step_index_reg <= '0;
            sounding_reg   <= 1'b0;
            for (int i = 0; i < PATTERN_DEPTH; i++)
            begin
                playing_reg[i] <= pattern_init(i);
                pending_reg[i] <= pattern_init(i);
            end
            division_reg   <= DIVISION_RESET;
            gate_reg       <= GATE_RESET;
            limit_reg      <= LIMIT_W'(STEPS);
            channel_reg    <= '0;
            vel_low_reg    <= VEL_LOW_RESET;
            vel_high_reg   <= VEL_HIGH_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            tick_reg       <= tick_next;
            step_index_reg <= step_index_next;
            sounding_reg   <= sounding_next;
            playing_reg    <= playing_next;
            pending_reg    <= pending_next;
            division_reg   <= division_next;
            gate_reg       <= gate_next;
            limit_reg      <= limit_next;
            channel_reg    <= channel_next;
            vel_low_reg    <= vel_low_next;
            vel_high_reg   <= vel_high_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload and scratch, no reset
    always_ff @(posedge clk)
    begin
        dividend_reg   <= dividend_next;
        rem_reg        <= rem_next;
        divisor_reg    <= divisor_next;
        qmod_reg       <= qmod_next;
        count_reg      <= count_next;
        draw_reg       <= draw_next;
        tick_rem_reg   <= tick_rem_next;
        note_reg       <= note_next;
        vel_reg        <= vel_next;
        is_on_reg      <= is_on_next;
        status_o_reg   <= status_o_next;
        number_o_reg   <= number_o_next;
        velocity_o_reg <= velocity_o_next;
    end

    assign in_ready      = (state_reg == ST_IDLE);
    assign out_valid     = out_valid_reg;
    assign note_status   = status_o_reg;
    assign note_number   = number_o_reg;
    assign note_velocity = velocity_o_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // the sounding flag only moves when a note item is loaded
    a_sounding_on_emit: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(sounding_reg) |-> $past(state_reg == ST_EMIT) && out_valid_reg)
        else $error("note_sounding changed without a note item");

    // velocity bounds keep their order, so the span never wraps
    a_vel_order: assert property (@(posedge clk) disable iff (!rst_n)
        vel_low_reg <= vel_high_reg)
        else $error("velocity low above velocity high");

    // a note item is on or off, and a note-off carries zero velocity
    a_note_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (status_o_reg[7:4] == STATUS_NOTE_ON) ||
            (status_o_reg[7:4] == STATUS_NOTE_OFF && velocity_o_reg == '0))
        else $error("bad note item");

endmodule

>>> verif/midi_clocked_step_sequencer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_clocked_step_sequencer_tb
// Self-checking bench for the MIDI-clocked step sequencer: directed and
// random MIDI streams, predicted notes checked in order, random idling and
// one long output stall.
// ----------------------------------------------------------------------------
module midi_clocked_step_sequencer_tb;

    import msseq_pkg::*;

    // ------------------------------------------------------------------------
    // Clock, reset and DUT ports. Every input starts at a known value.
    // ------------------------------------------------------------------------
    logic       clk           = 1'b0;
    logic       rst_n         = 1'b0;
    logic       in_valid      = 1'b0;
    logic       in_ready;
    logic [7:0] status_byte   = '0;
    logic [6:0] data_one      = '0;
    logic [6:0] data_two      = '0;
    logic [6:0] random_draw   = '0;
    logic       out_valid;
    logic       out_ready     = 1'b0;
    logic [7:0] note_status;
    logic [6:0] note_number;
    logic [6:0] note_velocity;

    always #4 clk = ~clk;

    midi_clocked_step_sequencer i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .status_byte   (status_byte),
        .data_one      (data_one),
        .data_two      (data_two),
        .random_draw   (random_draw),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .note_status   (note_status),
        .note_number   (note_number),
        .note_velocity (note_velocity)
    );

    // ------------------------------------------------------------------------
    // Expected note messages, oldest first
    // ------------------------------------------------------------------------
    typedef struct packed {
        logic [7:0] status;
        logic [6:0] number;
        logic [6:0] velocity;
    } note_msg_t;

    note_msg_t expected_notes[$];

    int  error_count  = 0;
    int  active_items = 0;   // items that change sequencer state
    bit  in_idle_en   = 1'b1;
    bit  out_idle_en  = 1'b1;
    int  out_hold_cycles = 0; // long receiver stall, served by the ready process

    // Append one predicted note at the tail of the queue
    function automatic void add_expected(input note_msg_t msg);
        expected_notes.insert(expected_notes.size(), msg);
    endfunction

    // ------------------------------------------------------------------------
    // Sequencer predictor state
    // ------------------------------------------------------------------------
    logic [31:0] seq_tick;
    logic [3:0]  seq_step;
    bit          seq_sounding;
    logic [6:0]  seq_playing[PATTERN_DEPTH];
    logic [6:0]  seq_pending[PATTERN_DEPTH];
    logic [6:0]  seq_division;
    logic [6:0]  seq_gate;
    logic [4:0]  seq_limit;
    logic [3:0]  seq_channel;
    logic [6:0]  seq_vel_low;
    logic [6:0]  seq_vel_high;

    function automatic int clamp_int(input int v, input int lo, input int hi);
        if (v < lo)
            v = lo;
        if (v > hi)
            v = hi;
        return v;
    endfunction

    function automatic void seq_reset();
        seq_tick     = '0;
        seq_step     = '0;
        seq_sounding = 1'b0;
        for (int i = 0; i < PATTERN_DEPTH; i++)
        begin
            seq_playing[i] = (i % 4 == 0) ? 7'd60 : 7'd127;
            seq_pending[i] = seq_playing[i];
        end
        seq_division = 7'd6;
        seq_gate     = 7'd1;
        seq_limit    = 5'd16;
        seq_channel  = 4'd0;
        seq_vel_low  = 7'd99;
        seq_vel_high = 7'd127;
    endfunction

    // Advance the sequencer by one clock tick; queue a note on or off if due
    function automatic void seq_clock_tick(input logic [6:0] draw);
        logic [31:0] rem;
        logic [6:0]  note;
        int          span;
        note_msg_t   msg;
        seq_tick = seq_tick + 32'd1;
        seq_step = 4'((seq_tick / {25'd0, seq_division}) % {27'd0, seq_limit});
        if (seq_step == 4'd0)
        begin
            for (int i = 0; i < STEPS_DEFAULT; i++)
                seq_playing[i] = seq_pending[i];
        end
        rem  = seq_tick % {25'd0, seq_division};
        note = seq_playing[seq_step];
        if (rem == 32'd0 && note < NOTE_REST && !seq_sounding)
        begin
            span = int'(seq_vel_high) - int'(seq_vel_low);
            msg.status   = {STATUS_NOTE_ON, seq_channel};
            msg.number   = note;
            msg.velocity = 7'(int'(seq_vel_low) + int'(draw) % (span + 1));
            add_expected(msg);
            seq_sounding = 1'b1;
        end
        else if (rem == {25'd0, seq_gate} && seq_sounding)
        begin
            msg.status   = {STATUS_NOTE_OFF, seq_channel};
            msg.number   = note;
            msg.velocity = 7'd0;
            add_expected(msg);
            seq_sounding = 1'b0;
        end
    endfunction

    // Control change; returns 1 when the controller is one the sequencer uses
    function automatic bit seq_control(input logic [6:0] cc, input logic [6:0] v);
        int c;
        int idx;
        c = int'(cc) - 1;
        if (cc >= CC_STEP_FIRST && cc <= CC_STEP_LAST)
        begin
            // controllers come in groups of four, last group maps to step 0
            idx = (3 - c / 4) * 4 + c % 4;
            if (idx < STEPS_DEFAULT)
                seq_pending[idx] = v;
            return 1'b1;
        end
        case (cc)
            CC_DIVISION: seq_division = 7'(clamp_int(int'(v), 1, 95));
            CC_GATE:     seq_gate     = 7'(clamp_int(int'(v), 1, 96 / int'(seq_limit) - 1));
            CC_LIMIT:    seq_limit    = 5'(clamp_int(int'(v), 1, STEPS_DEFAULT));
            CC_CHANNEL:  seq_channel  = 4'(clamp_int(int'(v), 0, 15));
            CC_VEL_LOW:  seq_vel_low  = 7'(clamp_int(int'(v), 0, int'(seq_vel_high)));
            CC_VEL_HIGH: seq_vel_high = 7'(clamp_int(int'(v), int'(seq_vel_low), 127));
            default:     return 1'b0;
        endcase
        return 1'b1;
    endfunction

    // One accepted MIDI message; returns 1 when it had any effect
    function automatic bit seq_message(input logic [7:0] st, input logic [6:0] d1,
                                       input logic [6:0] d2, input logic [6:0] draw);
        if (st == STATUS_CLOCK)
        begin
            seq_clock_tick(draw);
            return 1'b1;
        end
        if (st == STATUS_START)
        begin
            // sounding flag deliberately left alone
            seq_tick = '1;
            seq_step = '0;
            return 1'b1;
        end
        if (st[7:4] == STATUS_CC_HI)
            return seq_control(d1, d2);
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------------
    // Sender. in_valid is left high after acceptance; the next call either
    // re-raises it in the same step or lowers it for a gap.
    // ------------------------------------------------------------------------
    task automatic send_item(input logic [7:0] st, input logic [6:0] d1,
                             input logic [6:0] d2, input logic [6:0] draw);
        int gap;
        gap = in_idle_en ? $urandom_range(0, 7) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        status_byte <= st;
        data_one    <= d1;
        data_two    <= d2;
        random_draw <= draw;
        do
            @(posedge clk);
        while (!in_ready);
        if (seq_message(st, d1, d2, draw))
            active_items++;
    endtask

    task automatic send_clock();
        send_item(STATUS_CLOCK, 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                  7'($urandom_range(0, 127)));
    endtask

    task automatic send_start();
        send_item(STATUS_START, 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                  7'($urandom_range(0, 127)));
    endtask

    // Control change on a random MIDI channel
    task automatic send_cc(input logic [6:0] cc, input logic [6:0] v);
        send_item({STATUS_CC_HI, 4'($urandom_range(0, 15))}, cc, v,
                  7'($urandom_range(0, 127)));
    endtask

    // Wait until every predicted note has come out, then let the block settle
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        while (expected_notes.size() > 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random hold-off per result, plus the long stall on request
    // ------------------------------------------------------------------------
    initial
    begin : ready_driver
        int wait_cycles;
        @(posedge rst_n);
        forever
        begin
            if (out_hold_cycles > 0)
            begin
                out_ready <= 1'b0;
                repeat (out_hold_cycles) @(posedge clk);
                out_hold_cycles = 0;
            end
            wait_cycles = out_idle_en ? $urandom_range(0, 7) : 0;
            if (wait_cycles > 0)
            begin
                out_ready <= 1'b0;
                repeat (wait_cycles) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid && out_hold_cycles == 0);
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: every accepted note against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        note_msg_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_notes.size() == 0)
            begin
                $display("%0t: unexpected note: expected none, actual %h %h %h", $time,
                         note_status, note_number, note_velocity);
                error_count++;
            end
            else
            begin
                want = expected_notes.pop_front();
                if (note_status !== want.status)
                begin
                    $display("%0t: note_status mismatch: expected %h, actual %h", $time,
                             want.status, note_status);
                    error_count++;
                end
                if (note_number !== want.number)
                begin
                    $display("%0t: note_number mismatch: expected %0d, actual %0d", $time,
                             want.number, note_number);
                    error_count++;
                end
                if (note_velocity !== want.velocity)
                begin
                    $display("%0t: note_velocity mismatch: expected %0d, actual %0d", $time,
                             want.velocity, note_velocity);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Power-up pattern, start, one note on/off, ignored messages, step edits
    task automatic test_defaults_and_ignored();
        send_start();
        send_item(STATUS_CLOCK, 7'd0, 7'd0, 7'd127);    // tick 0: note on
        send_item(STATUS_CLOCK, 7'd127, 7'd127, 7'd0);  // gate reached: note off
        send_item(8'h90, 7'd127, 7'd127, 7'd127);       // note on in: ignored
        send_item(8'h00, 7'd0, 7'd0, 7'd0);
        send_item(8'hFF, 7'd127, 7'd127, 7'd127);
        send_item({STATUS_CC_HI, 4'hF}, 7'd0, 7'd127, 7'd0);   // unused controller
        send_item({STATUS_CC_HI, 4'h0}, 7'd127, 7'd0, 7'd127);
        send_cc(7'd13, 7'd0);     // pending step 0 -> note 0
        send_cc(7'd1, 7'd127);    // pending step 12 -> rest
    endtask

    // Every setting at its extremes, with clamping
    task automatic test_setting_extremes();
        send_cc(CC_VEL_LOW, 7'd0);
        send_cc(CC_VEL_HIGH, 7'd127);     // widest velocity span
        send_cc(CC_CHANNEL, 7'd127);      // clamps to 15
        send_cc(CC_LIMIT, 7'd0);          // clamps to 1
        send_cc(CC_GATE, 7'd127);         // clamps to 95 with one step
        send_cc(CC_DIVISION, 7'd127);     // clamps to 95
        send_cc(CC_GATE, 7'd0);           // clamps to 1
        send_start();
        send_item(STATUS_CLOCK, 7'd0, 7'd0, 7'd127);   // new pattern copied, note 0
        send_item(STATUS_CLOCK, 7'd0, 7'd0, 7'd0);
        send_cc(CC_DIVISION, 7'd0);       // division of one: no note off ever
        send_start();
        send_clock();
        send_clock();
        send_cc(CC_DIVISION, 7'd6);
        send_cc(CC_LIMIT, 7'd127);        // clamps to 16
        send_cc(CC_VEL_HIGH, 7'd0);       // clamps up to the low bound
        send_cc(CC_VEL_LOW, 7'd127);      // clamps down to the high bound
        wait_for_drain();
    endtask

    // One random run: program settings and pattern, mostly start, then clock it amid other messages
    task automatic run_random_round(input int clocks);
        int div;
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            div = 1;
        else if (pick == 1)
            div = $urandom_range(13, 127);
        else
            div = $urandom_range(2, 10);
        send_cc(CC_LIMIT, ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 127))
                                                     : 7'($urandom_range(1, 16)));
        send_cc(CC_DIVISION, 7'(div));
        send_cc(CC_GATE, ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 127))
                                                    : 7'($urandom_range(0, div - 1)));
        send_cc(CC_CHANNEL, ($urandom_range(0, 5) == 0) ? 7'($urandom_range(0, 127))
                                                       : 7'($urandom_range(0, 15)));
        if ($urandom_range(0, 1))
        begin
            send_cc(CC_VEL_LOW, 7'($urandom_range(0, 127)));
            send_cc(CC_VEL_HIGH, 7'($urandom_range(0, 127)));
        end
        else
        begin
            send_cc(CC_VEL_HIGH, 7'($urandom_range(0, 127)));
            send_cc(CC_VEL_LOW, 7'($urandom_range(0, 127)));
        end
        repeat ($urandom_range(2, 12))
            send_cc(7'($urandom_range(1, 16)), ($urandom_range(0, 3) == 0)
                    ? NOTE_REST : 7'($urandom_range(0, 127)));
        if ($urandom_range(0, 4) != 0)
            send_start();
        repeat (clocks)
        begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
                send_item(7'($urandom_range(0, 255)) == 0 ? 8'h00 : 8'($urandom_range(0, 255)),
                          7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                          7'($urandom_range(0, 127)));
            else if (pick == 1)
                send_cc(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
            else if (pick == 2)
                send_start();
            else
                send_clock();
        end
    endtask

    // Random runs; each picks its own idling mode, including none at all
    task automatic test_random_runs();
        int target;
        int mode;
        target = active_items + 1200;
        while (active_items < target)
        begin
            mode = $urandom_range(0, 3);
            in_idle_en  = mode[0];
            out_idle_en = mode[1];
            run_random_round($urandom_range(15, 60));
        end
        in_idle_en  = 1'b1;
        out_idle_en = 1'b1;
        wait_for_drain();
    endtask

    // Receiver stalls for a long time while the sender keeps offering clocks
    // that each produce a note; the block has to stall its input.
    task automatic test_output_backpressure();
        send_cc(CC_LIMIT, 7'd16);
        send_cc(CC_DIVISION, 7'd2);
        send_cc(CC_GATE, 7'd1);
        for (int c = 1; c <= 16; c++)
            send_cc(7'(c), 7'($urandom_range(0, 126)));
        send_start();
        in_valid <= 1'b0;
        @(posedge clk);
        out_hold_cycles = 3000;
        in_idle_en = 1'b0;
        repeat (40) send_clock();
        in_idle_en = 1'b1;
        wait_for_drain();
    endtask

    // ------------------------------------------------------------------------
    // Sequence of tests
    // ------------------------------------------------------------------------
    initial
    begin
        seq_reset();
        rst_n <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_defaults_and_ignored();
        test_setting_extremes();
        test_random_runs();
        test_output_backpressure();

        wait_for_drain();
        repeat (100) @(posedge clk);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Watchdog, several times the slowest legal run
    initial
    begin
        #5000000;
        $display("Some tests failed");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/msseq_pkg.sv
rtl/core/midi_clocked_step_sequencer.sv
verif/midi_clocked_step_sequencer_tb.sv
